// ----- rtl/sas_pkg.sv -----
`default_nettype none

package sas_pkg;

    // list geometry
    localparam int LIST_DEPTH   = 32;
    localparam int NODE_ID_BITS = 16;
    localparam int A_DEPTH      = 2 * LIST_DEPTH;
    localparam int A_AW         = $clog2(A_DEPTH);
    localparam int A_CW         = $clog2(A_DEPTH + 1);
    localparam int B_AW         = $clog2(LIST_DEPTH);
    localparam int B_CW         = $clog2(LIST_DEPTH + 1);

    // key = {node_id, time_frame, value}, sorts as plain unsigned
    localparam int KEY_W = NODE_ID_BITS + 2;

    // stream widths
    localparam int OUT_ID_W    = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [1:0] {
        KIND_LOAD_A = 2'd0,
        KIND_LOAD_B = 2'd1,
        KIND_RUN    = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_UNION   = 2'd0,
        OP_DIFF    = 2'd1,
        OP_COMPARE = 2'd2,
        OP_SANITY  = 2'd3
    } op_t;

    localparam logic [2:0] REL_CONFLICT = 3'd0;
    localparam logic [2:0] REL_UNRELATED = 3'd1;
    localparam logic [2:0] REL_A_HAS_B  = 3'd2;
    localparam logic [2:0] REL_B_HAS_A  = 3'd3;
    localparam logic [2:0] REL_EQUAL    = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MERGE,
        ST_COMPARE,
        ST_SANITY,
        ST_COPY_START,
        ST_COPY,
        ST_RESULT
    } state_t;

    // one result beat
    typedef struct packed {
        logic                last;
        logic                overflow;
        logic                sane;
        logic [2:0]          relation;
        logic                element_valid;
        logic                value;
        logic                time_frame;
        logic [OUT_ID_W-1:0] node_id;
    } beat_t;

endpackage

`default_nettype wire

// ----- rtl/sas_ram.sv -----
`default_nettype none

module sas_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/sas_obuf.sv -----
`default_nettype none

module sas_obuf (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             load,
    input  wire sas_pkg::beat_t                   beat_in,
    output logic                                  free,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [sas_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                  m_tuser,
    output logic                                  m_tlast
);

    logic           valid_reg;
    logic           valid_next;
    sas_pkg::beat_t beat_reg;

    // slot frees up when empty or when the waiting beat goes this cycle
    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= beat_in;
        end
    end

    // tdata: node_id, time_frame, value, relation, sane, overflow, pad
    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, beat_reg.overflow, beat_reg.sane, beat_reg.relation,
                       beat_reg.value, beat_reg.time_frame, beat_reg.node_id};
    assign m_tuser  = beat_reg.element_valid;
    assign m_tlast  = beat_reg.last;

endmodule

`default_nettype wire

// ----- rtl/sas_engine.sv -----
`default_nettype none

module sas_engine (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // item side
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire sas_pkg::kind_t              in_kind,
    input  wire logic [sas_pkg::KEY_W-1:0]   in_key,
    // operation register
    input  wire logic                        cfg_we,
    input  wire logic [1:0]                  cfg_wdata,
    // list A memory
    output logic                             a_we,
    output logic [sas_pkg::A_AW-1:0]         a_waddr,
    output logic [sas_pkg::KEY_W-1:0]        a_wdata,
    output logic [sas_pkg::A_AW-1:0]         a_raddr,
    input  wire logic [sas_pkg::KEY_W-1:0]   a_rdata,
    // list B memory
    output logic                             b_we,
    output logic [sas_pkg::B_AW-1:0]         b_waddr,
    output logic [sas_pkg::KEY_W-1:0]        b_wdata,
    output logic [sas_pkg::B_AW-1:0]         b_raddr,
    input  wire logic [sas_pkg::KEY_W-1:0]   b_rdata,
    // merge scratch memory
    output logic                             r_we,
    output logic [sas_pkg::A_AW-1:0]         r_waddr,
    output logic [sas_pkg::KEY_W-1:0]        r_wdata,
    output logic [sas_pkg::A_AW-1:0]         r_raddr,
    input  wire logic [sas_pkg::KEY_W-1:0]   r_rdata,
    // result slot
    input  wire logic                        ob_free,
    output logic                             beat_load,
    output sas_pkg::beat_t                   beat
);

    localparam int KW = sas_pkg::KEY_W;

    sas_pkg::state_t            state_reg, state_next;
    sas_pkg::op_t               op_reg, op_next;
    logic [sas_pkg::A_CW-1:0]   ca_reg, ca_next;
    logic [sas_pkg::B_CW-1:0]   cb_reg, cb_next;
    logic                       ovf_reg, ovf_next;
    logic [sas_pkg::A_CW-1:0]   i1_reg, i1_next;
    logic [sas_pkg::B_CW-1:0]   i2_reg, i2_next;
    logic [sas_pkg::A_CW-1:0]   n_reg, n_next;
    logic [1:0]                 ans_reg, ans_next;
    logic [2:0]                 rel_reg, rel_next;
    logic                       sane_reg, sane_next;
    logic [KW-1:0]              prev_reg, prev_next;

    logic                       accept;
    logic                       have_a, have_b, is_union, same_slot;
    logic                       adv_a, adv_b, push_en, walk_done, conflict;
    logic [KW-1:0]              push_key;
    logic [1:0]                 ans_and, ans_fin;
    logic [sas_pkg::A_CW-1:0]   i1_step, i1_inc;
    logic [sas_pkg::B_CW-1:0]   i2_step;
    logic                       copy_last;

    assign in_ready  = (state_reg == sas_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign have_a    = (i1_reg < ca_reg);
    assign have_b    = (i2_reg < cb_reg);
    assign is_union  = (op_reg == sas_pkg::OP_UNION);
    assign same_slot = (a_rdata[KW-1:1] == b_rdata[KW-1:1]);
    assign i1_inc    = i1_reg + sas_pkg::A_CW'(1);
    assign i1_step   = i1_reg + sas_pkg::A_CW'(adv_a);
    assign i2_step   = i2_reg + sas_pkg::B_CW'(adv_b);
    assign copy_last = (i1_inc == ca_reg);
    assign ans_fin   = ans_reg & ans_and;

    // walk decode: one step of the pointer walk per cycle
    always_comb
    begin
        adv_a     = 1'b0;
        adv_b     = 1'b0;
        push_en   = 1'b0;
        push_key  = a_rdata;
        walk_done = 1'b0;
        conflict  = 1'b0;
        ans_and   = 2'b11;
        case (state_reg)
            sas_pkg::ST_MERGE:
            begin
                if (have_a && have_b)
                begin
                    if (a_rdata < b_rdata)
                    begin
                        push_en = 1'b1;
                        adv_a   = 1'b1;
                    end
                    else if (a_rdata > b_rdata)
                    begin
                        push_en  = is_union;
                        push_key = b_rdata;
                        adv_b    = 1'b1;
                    end
                    else
                    begin
                        push_en = is_union;
                        adv_a   = 1'b1;
                        adv_b   = 1'b1;
                    end
                end
                else if (have_a)
                begin
                    push_en = 1'b1;
                    adv_a   = 1'b1;
                end
                else if (have_b && is_union)
                begin
                    push_en  = 1'b1;
                    push_key = b_rdata;
                    adv_b    = 1'b1;
                end
                else
                begin
                    walk_done = 1'b1;
                end
            end
            sas_pkg::ST_COMPARE:
            begin
                if (have_a && have_b)
                begin
                    if (same_slot)
                    begin
                        if (a_rdata[0] != b_rdata[0])
                        begin
                            conflict = 1'b1;
                        end
                        else
                        begin
                            adv_a = 1'b1;
                            adv_b = 1'b1;
                        end
                    end
                    else if (a_rdata < b_rdata)
                    begin
                        ans_and = 2'b01;
                        adv_a   = 1'b1;
                    end
                    else
                    begin
                        ans_and = 2'b10;
                        adv_b   = 1'b1;
                    end
                end
                else
                begin
                    walk_done = 1'b1;
                    ans_and   = (have_a ? 2'b01 : 2'b11) & (have_b ? 2'b10 : 2'b11);
                end
            end
            sas_pkg::ST_SANITY:
            begin
                if (have_a)
                begin
                    if ((i1_reg != '0) && (prev_reg[KW-1:1] == a_rdata[KW-1:1])
                        && (prev_reg[0] != a_rdata[0]))
                    begin
                        conflict = 1'b1;
                    end
                    else
                    begin
                        adv_a = 1'b1;
                    end
                end
                else
                begin
                    walk_done = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sas_pkg::ST_IDLE:
            begin
                if (accept && (in_kind == sas_pkg::KIND_RUN))
                begin
                    unique case (op_reg)
                        sas_pkg::OP_UNION,
                        sas_pkg::OP_DIFF:    state_next = sas_pkg::ST_MERGE;
                        sas_pkg::OP_COMPARE: state_next = sas_pkg::ST_COMPARE;
                        sas_pkg::OP_SANITY:  state_next = sas_pkg::ST_SANITY;
                        default:             state_next = sas_pkg::ST_IDLE;
                    endcase
                end
            end
            sas_pkg::ST_MERGE:
            begin
                if (walk_done)
                begin
                    state_next = sas_pkg::ST_COPY_START;
                end
            end
            sas_pkg::ST_COMPARE,
            sas_pkg::ST_SANITY:
            begin
                if (walk_done || conflict)
                begin
                    state_next = sas_pkg::ST_RESULT;
                end
            end
            sas_pkg::ST_COPY_START:
            begin
                state_next = (ca_reg == '0) ? sas_pkg::ST_RESULT : sas_pkg::ST_COPY;
            end
            sas_pkg::ST_COPY:
            begin
                if (ob_free && copy_last)
                begin
                    state_next = sas_pkg::ST_IDLE;
                end
            end
            sas_pkg::ST_RESULT:
            begin
                if (ob_free)
                begin
                    state_next = sas_pkg::ST_IDLE;
                end
            end
            default: state_next = sas_pkg::ST_IDLE;
        endcase
    end

    // datapath, memory ports and result beats
    always_comb
    begin
        op_next   = op_reg;
        ca_next   = ca_reg;
        cb_next   = cb_reg;
        ovf_next  = ovf_reg;
        i1_next   = i1_reg;
        i2_next   = i2_reg;
        n_next    = n_reg;
        ans_next  = ans_reg;
        rel_next  = rel_reg;
        sane_next = sane_reg;
        prev_next = prev_reg;

        a_we    = 1'b0;
        a_waddr = ca_reg[sas_pkg::A_AW-1:0];
        a_wdata = in_key;
        a_raddr = '0;
        b_we    = 1'b0;
        b_waddr = cb_reg[sas_pkg::B_AW-1:0];
        b_wdata = in_key;
        b_raddr = '0;
        r_we    = 1'b0;
        r_waddr = n_reg[sas_pkg::A_AW-1:0];
        r_wdata = push_key;
        r_raddr = '0;

        beat_load          = 1'b0;
        beat               = '0;
        beat.overflow      = ovf_reg;
        beat.last          = 1'b1;

        if (cfg_we)
        begin
            op_next = sas_pkg::op_t'(cfg_wdata);
        end

        unique case (state_reg)
            sas_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_kind)
                        sas_pkg::KIND_LOAD_A:
                        begin
                            if (ca_reg < sas_pkg::A_CW'(sas_pkg::A_DEPTH))
                            begin
                                a_we    = 1'b1;
                                ca_next = ca_reg + sas_pkg::A_CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        sas_pkg::KIND_LOAD_B:
                        begin
                            if (cb_reg < sas_pkg::B_CW'(sas_pkg::LIST_DEPTH))
                            begin
                                b_we    = 1'b1;
                                cb_next = cb_reg + sas_pkg::B_CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        sas_pkg::KIND_RUN:
                        begin
                            // walk starts at the heads; reads of entry 0 go out now
                            i1_next  = '0;
                            i2_next  = '0;
                            n_next   = '0;
                            ans_next = 2'b11;
                        end
                        sas_pkg::KIND_CLEAR:
                        begin
                            ca_next  = '0;
                            cb_next  = '0;
                            ovf_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            sas_pkg::ST_MERGE:
            begin
                a_raddr = i1_step[sas_pkg::A_AW-1:0];
                b_raddr = i2_step[sas_pkg::B_AW-1:0];
                i1_next = i1_step;
                i2_next = i2_step;
                if (push_en)
                begin
                    if (n_reg < sas_pkg::A_CW'(sas_pkg::A_DEPTH))
                    begin
                        r_we   = 1'b1;
                        n_next = n_reg + sas_pkg::A_CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                if (walk_done)
                begin
                    ca_next = n_reg;
                    i1_next = '0;
                end
            end
            sas_pkg::ST_COMPARE:
            begin
                a_raddr  = i1_step[sas_pkg::A_AW-1:0];
                b_raddr  = i2_step[sas_pkg::B_AW-1:0];
                i1_next  = i1_step;
                i2_next  = i2_step;
                ans_next = ans_fin;
                if (conflict)
                begin
                    rel_next = sas_pkg::REL_CONFLICT;
                end
                else if (walk_done)
                begin
                    rel_next = 3'(ans_fin) + sas_pkg::REL_UNRELATED;
                end
            end
            sas_pkg::ST_SANITY:
            begin
                a_raddr = i1_step[sas_pkg::A_AW-1:0];
                i1_next = i1_step;
                if (adv_a)
                begin
                    prev_next = a_rdata;
                end
                if (conflict)
                begin
                    sane_next = 1'b0;
                end
                else if (walk_done)
                begin
                    sane_next = 1'b1;
                end
            end
            sas_pkg::ST_COPY_START:
            begin
                r_raddr = '0;
            end
            sas_pkg::ST_COPY:
            begin
                // scratch entry goes out and back into list A in the same cycle
                r_raddr = i1_reg[sas_pkg::A_AW-1:0];
                if (ob_free)
                begin
                    r_raddr            = i1_inc[sas_pkg::A_AW-1:0];
                    i1_next            = i1_inc;
                    a_we               = 1'b1;
                    a_waddr            = i1_reg[sas_pkg::A_AW-1:0];
                    a_wdata            = r_rdata;
                    beat_load          = 1'b1;
                    beat.node_id       = sas_pkg::OUT_ID_W'(r_rdata[KW-1:2]);
                    beat.time_frame    = r_rdata[1];
                    beat.value         = r_rdata[0];
                    beat.element_valid = 1'b1;
                    beat.last          = copy_last;
                end
            end
            sas_pkg::ST_RESULT:
            begin
                beat_load = ob_free;
                if (op_reg == sas_pkg::OP_COMPARE)
                begin
                    beat.relation = rel_reg;
                end
                if (op_reg == sas_pkg::OP_SANITY)
                begin
                    beat.sane = sane_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sas_pkg::ST_IDLE;
            op_reg    <= sas_pkg::OP_UNION;
            ca_reg    <= '0;
            cb_reg    <= '0;
            ovf_reg   <= 1'b0;
            i1_reg    <= '0;
            i2_reg    <= '0;
            n_reg     <= '0;
            ans_reg   <= 2'b11;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            ca_reg    <= ca_next;
            cb_reg    <= cb_next;
            ovf_reg   <= ovf_next;
            i1_reg    <= i1_next;
            i2_reg    <= i2_next;
            n_reg     <= n_next;
            ans_reg   <= ans_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        rel_reg  <= rel_next;
        sane_reg <= sane_next;
        prev_reg <= prev_next;
    end

endmodule

`default_nettype wire

// ----- rtl/sorted_assignment_set_ops_unit.sv -----
// Set operations on two sorted lists of signal assignments.
// Input stream (s_*): one beat per item. s_tuser is the item kind (load A,
// load B, run, clear); s_tdata carries node_id, time_frame and value.
// Loads and clears are taken back to back while idle. A run applies the
// operation held in the register written through cfg_we / cfg_wdata.
// Union and difference walk both lists at one element per cycle, then stream
// the result back into list A and out on m_* at one beat per cycle while
// m_tready does not stall it; an empty result gives a single beat with no
// element. Compare walks both lists and sanity walks list A.
// Each list memory has one registered read port.
// m_tuser is 1 on beats that carry an element, m_tlast marks the final beat.
// s_tready is low while a run is in progress. A stalled m_tready holds the
// result stage and pauses the stream; loads are still taken while the last
// beat of a run waits.
// Reset empties both lists, clears the overflow flag and selects union;
// list memories are not cleared and need no clearing pass.
`default_nettype none

module sorted_assignment_set_ops_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sas_pkg::IN_TDATA_W-1:0]    s_tdata,  // node_id, time_frame, value
    input  wire logic [1:0]                        s_tuser,  // kind
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_node_id, out_time_frame, out_value, relation, sane, overflow
    output logic [sas_pkg::OUT_TDATA_W-1:0]        m_tdata,
    output logic                                   m_tuser,  // element_valid
    output logic                                   m_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [1:0]                        cfg_wdata
);

    localparam int KW = sas_pkg::KEY_W;

    logic [KW-1:0]             in_key;
    logic                      a_we, b_we, r_we;
    logic [sas_pkg::A_AW-1:0]  a_waddr, a_raddr, r_waddr, r_raddr;
    logic [sas_pkg::B_AW-1:0]  b_waddr, b_raddr;
    logic [KW-1:0]             a_wdata, a_rdata, b_wdata, b_rdata, r_wdata, r_rdata;
    logic                      ob_free;
    logic                      beat_load;
    sas_pkg::beat_t            beat;

    // key sorts by node, then time frame, then value
    assign in_key = {s_tdata[sas_pkg::NODE_ID_BITS-1:0], s_tdata[16], s_tdata[17]};

    sas_ram #(
        .WIDTH (KW),
        .DEPTH (sas_pkg::A_DEPTH)
    ) u_list_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    sas_ram #(
        .WIDTH (KW),
        .DEPTH (sas_pkg::LIST_DEPTH)
    ) u_list_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    sas_ram #(
        .WIDTH (KW),
        .DEPTH (sas_pkg::A_DEPTH)
    ) u_scratch (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    sas_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (sas_pkg::kind_t'(s_tuser)),
        .in_key    (in_key),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .a_we      (a_we),
        .a_waddr   (a_waddr),
        .a_wdata   (a_wdata),
        .a_raddr   (a_raddr),
        .a_rdata   (a_rdata),
        .b_we      (b_we),
        .b_waddr   (b_waddr),
        .b_wdata   (b_wdata),
        .b_raddr   (b_raddr),
        .b_rdata   (b_rdata),
        .r_we      (r_we),
        .r_waddr   (r_waddr),
        .r_wdata   (r_wdata),
        .r_raddr   (r_raddr),
        .r_rdata   (r_rdata),
        .ob_free   (ob_free),
        .beat_load (beat_load),
        .beat      (beat)
    );

    sas_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (beat_load),
        .beat_in  (beat),
        .free     (ob_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // engine never overwrites a beat that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n) beat_load |-> ob_free)
        else $error("result beat loaded while slot busy");

    // element beats carry no relation or sanity flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[21:18] == 4'd0))
        else $error("element beat with relation or sane set");

    // a run always keeps the input side busy in the cycle after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == sas_pkg::KIND_RUN)) |=> !s_tready)
        else $error("input taken right after a run beat");

endmodule

`default_nettype wire

// ----- tb/sv/sas_result_checker.sv -----
`timescale 1ns / 100ps

module sas_result_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [sas_pkg::IN_TDATA_W-1:0] s_tdata,   // node_id, time_frame, value
    input  wire logic [1:0]                     s_tuser,   // kind
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    // out_node_id, out_time_frame, out_value, relation, sane, overflow
    input  wire logic [sas_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                           m_tuser,   // element_valid
    input  wire logic                           m_tlast,
    input  wire logic                           cfg_we,
    input  wire logic [1:0]                     cfg_wdata,
    output int                                  errors,
    output int                                  pending
);

    import sas_pkg::*;

    localparam int         MAX_REPORTS = 10;
    // relation field outside of a compare result
    localparam logic [2:0] REL_NONE    = 3'd0;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic [OUT_ID_W-1:0] node_id;
        logic                time_frame;
        logic                value;
        logic                element_valid;
        logic [2:0]          relation;
        logic                sane;
        logic                overflow;
        logic                last;
    } set_beat_t;

    // mirrored block state
    key_t      list_a [A_DEPTH];
    key_t      list_b [LIST_DEPTH];
    key_t      merge_buf [A_DEPTH];
    int        count_a;
    int        count_b;
    logic      overflow_seen;
    op_t       op_sel;
    int        fail_count;
    set_beat_t expected_beats [$];

    function automatic set_beat_t make_beat(input logic elem, input key_t key,
                                            input logic [2:0] rel, input logic sane,
                                            input logic last);
        set_beat_t b;
        b = '0;
        if (elem)
        begin
            b.node_id    = key[KEY_W-1:2];
            b.time_frame = key[1];
            b.value      = key[0];
        end
        b.element_valid = elem;
        b.relation      = rel;
        b.sane          = sane;
        b.overflow      = overflow_seen;
        b.last          = last;
        return b;
    endfunction

    // queue one predicted beat at the tail
    function automatic void expect_beat(input set_beat_t b);
        expected_beats.insert(expected_beats.size(), b);
    endfunction

    function automatic string beat_text(input set_beat_t b);
        return $sformatf("id=%h tf=%0d v=%0d elem=%0d rel=%0d sane=%0d ovf=%0d last=%0d",
                         b.node_id, b.time_frame, b.value, b.element_valid, b.relation,
                         b.sane, b.overflow, b.last);
    endfunction

    // merge result is cut at the capacity of list A
    task automatic store_merged(inout int n, input key_t key);
        if (n < A_DEPTH)
        begin
            merge_buf[n] = key;
            n++;
        end
        else
            overflow_seen = 1'b1;
    endtask

    // union (keep_b) or difference A minus B, written back to A and streamed
    task automatic merge_lists(input logic keep_b);
        int   ia;
        int   ib;
        int   n;
        int   i;
        key_t ka;
        key_t kb;
        ia = 0;
        ib = 0;
        n  = 0;
        while (ia < count_a && ib < count_b)
        begin
            ka = list_a[ia];
            kb = list_b[ib];
            if (ka < kb)
            begin
                store_merged(n, ka);
                ia++;
            end
            else if (ka > kb)
            begin
                if (keep_b)
                    store_merged(n, kb);
                ib++;
            end
            else
            begin
                if (keep_b)
                    store_merged(n, ka);
                ia++;
                ib++;
            end
        end
        while (ia < count_a)
        begin
            store_merged(n, list_a[ia]);
            ia++;
        end
        if (keep_b)
        begin
            while (ib < count_b)
            begin
                store_merged(n, list_b[ib]);
                ib++;
            end
        end
        for (i = 0; i < n; i++)
            list_a[i] = merge_buf[i];
        count_a = n;
        if (n == 0)
            expect_beat(make_beat(1'b0, '0, REL_NONE, 1'b0, 1'b1));
        for (i = 0; i < n; i++)
            expect_beat(make_beat(1'b1, list_a[i], REL_NONE, 1'b0, i == n - 1));
    endtask

    function automatic logic [2:0] list_relation();
        int   ia;
        int   ib;
        logic a_extra;
        logic b_extra;
        key_t ka;
        key_t kb;
        ia      = 0;
        ib      = 0;
        a_extra = 1'b0;
        b_extra = 1'b0;
        while (ia < count_a && ib < count_b)
        begin
            ka = list_a[ia];
            kb = list_b[ib];
            // same node and time frame: values must agree
            if (ka[KEY_W-1:1] == kb[KEY_W-1:1])
            begin
                if (ka[0] != kb[0])
                    return REL_CONFLICT;
                ia++;
                ib++;
            end
            else if (ka < kb)
            begin
                a_extra = 1'b1;
                ia++;
            end
            else
            begin
                b_extra = 1'b1;
                ib++;
            end
        end
        if (ia < count_a)
            a_extra = 1'b1;
        if (ib < count_b)
            b_extra = 1'b1;
        if (a_extra && b_extra)
            return REL_UNRELATED;
        if (a_extra)
            return REL_A_HAS_B;
        if (b_extra)
            return REL_B_HAS_A;
        return REL_EQUAL;
    endfunction

    function automatic logic list_a_sane();
        int i;
        for (i = 1; i < count_a; i++)
        begin
            if (list_a[i-1][KEY_W-1:1] == list_a[i][KEY_W-1:1] &&
                list_a[i-1][0] != list_a[i][0])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic apply_item();
        kind_t kind;
        key_t  key;
        kind = kind_t'(s_tuser);
        key  = {s_tdata[15:0], s_tdata[16], s_tdata[17]};
        case (kind)
            KIND_LOAD_A:
            begin
                if (count_a < A_DEPTH)
                begin
                    list_a[count_a] = key;
                    count_a++;
                end
                else
                    overflow_seen = 1'b1;
            end
            KIND_LOAD_B:
            begin
                if (count_b < LIST_DEPTH)
                begin
                    list_b[count_b] = key;
                    count_b++;
                end
                else
                    overflow_seen = 1'b1;
            end
            KIND_CLEAR:
            begin
                count_a       = 0;
                count_b       = 0;
                overflow_seen = 1'b0;
            end
            default:
            begin
                case (op_sel)
                    OP_UNION:   merge_lists(1'b1);
                    OP_DIFF:    merge_lists(1'b0);
                    OP_COMPARE: expect_beat(
                                    make_beat(1'b0, '0, list_relation(), 1'b0, 1'b1));
                    default:    expect_beat(
                                    make_beat(1'b0, '0, REL_NONE, list_a_sane(), 1'b1));
                endcase
            end
        endcase
    endtask

    task automatic check_beat();
        set_beat_t got;
        set_beat_t want;
        got.node_id       = m_tdata[15:0];
        got.time_frame    = m_tdata[16];
        got.value         = m_tdata[17];
        got.relation      = m_tdata[20:18];
        got.sane          = m_tdata[21];
        got.overflow      = m_tdata[22];
        got.element_valid = m_tuser;
        got.last          = m_tlast;
        if (expected_beats.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("[%0t] unexpected result beat: %s", $realtime, beat_text(got));
        end
        else
        begin
            want = expected_beats.pop_front();
            if (got.node_id !== want.node_id || got.time_frame !== want.time_frame ||
                got.value !== want.value || got.element_valid !== want.element_valid ||
                got.relation !== want.relation || got.sane !== want.sane ||
                got.overflow !== want.overflow || got.last !== want.last)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("[%0t] result mismatch\n  expected: %s\n  actual:   %s",
                             $realtime, beat_text(want), beat_text(got));
            end
        end
    endtask

    // beats leaving the block are checked before a new item is applied
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a       = 0;
            count_b       = 0;
            overflow_seen = 1'b0;
            op_sel        = OP_UNION;
            fail_count    = 0;
            expected_beats.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                op_sel = op_t'(cfg_wdata);
            if (m_tvalid && m_tready)
                check_beat();
            if (s_tvalid && s_tready)
                apply_item();
            errors  <= fail_count;
            pending <= expected_beats.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    import sas_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 150;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 200;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_we;
    logic [1:0]             cfg_wdata;

    int                     errors;
    int                     pending;
    int                     cycles = 0;
    int                     items_sent;
    logic                   no_idle;
    logic [KEY_W-1:0]       a_keys [$];
    logic [KEY_W-1:0]       b_keys [$];

    always #6 clk = ~clk;

    sorted_assignment_set_ops_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    sas_result_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side back-pressure, one draw per beat
    initial
    begin : ready_gen
        int stall;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // one input beat, returns at the accepting edge
    task automatic send_item(input kind_t kind, input logic [15:0] id, input logic tf,
                             input logic val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, val, tf, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_load(input kind_t kind, input logic [KEY_W-1:0] key);
        send_item(kind, key[KEY_W-1:2], key[1], key[0]);
    endtask

    task automatic send_filler(input kind_t kind);
        send_item(kind, 16'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // drain all results, then let loads and clears settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_operation(input op_t op);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= op;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // two sorted lists over eight neighboring nodes, B derived from A in all but one mode
    task automatic build_small_sets();
        int          base;
        int          mode;
        int          r;
        int          n;
        int          t;
        logic [15:0] id;
        logic        a0;
        logic        a1;
        logic        b0;
        logic        b1;
        a_keys.delete();
        b_keys.delete();
        r = $urandom_range(0, 3);
        base = (r == 0) ? $urandom_range(0, 4) :
               (r == 1) ? 65528 : $urandom_range(0, 65528);
        mode = $urandom_range(0, 4);
        for (n = 0; n < 8; n++)
        begin
            for (t = 0; t < 2; t++)
            begin
                id = 16'(base + n);
                r  = $urandom_range(0, 9);
                a0 = (r == 5) || (r == 6) || (r == 9);
                a1 = (r >= 7);
                case (mode)
                    0:
                    begin
                        r  = $urandom_range(0, 9);
                        b0 = (r == 5) || (r == 6) || (r == 9);
                        b1 = (r >= 7);
                    end
                    1:
                    begin
                        b0 = a0 & 1'($urandom_range(0, 1));
                        b1 = a1 & 1'($urandom_range(0, 1));
                    end
                    2:
                    begin
                        b0 = a0 | ($urandom_range(0, 7) == 0);
                        b1 = a1 | ($urandom_range(0, 7) == 0);
                    end
                    3:
                    begin
                        b0 = a0;
                        b1 = a1;
                    end
                    default:
                    begin
                        // equal lists with an occasional flipped value
                        if ($urandom_range(0, 3) == 0)
                        begin
                            b0 = a1;
                            b1 = a0;
                        end
                        else
                        begin
                            b0 = a0;
                            b1 = a1;
                        end
                    end
                endcase
                if (a0)
                    a_keys.insert(a_keys.size(), {id, 1'(t), 1'b0});
                if (a1)
                    a_keys.insert(a_keys.size(), {id, 1'(t), 1'b1});
                if (b0)
                    b_keys.insert(b_keys.size(), {id, 1'(t), 1'b0});
                if (b1)
                    b_keys.insert(b_keys.size(), {id, 1'(t), 1'b1});
            end
        end
    endtask

    // lists past capacity: A and B both overflow, union gets cut
    task automatic build_full_sets();
        int i;
        int base;
        a_keys.delete();
        b_keys.delete();
        base = $urandom_range(0, 65535 - 70);
        for (i = 0; i < A_DEPTH + 2; i++)
            a_keys.insert(a_keys.size(), {16'(base + i), 1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1))});
        for (i = 0; i < LIST_DEPTH + 1; i++)
            b_keys.insert(b_keys.size(), {16'(base + 2 * i), 1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1))});
    endtask

    task automatic random_sequence(input logic full);
        int               ia;
        int               ib;
        int               x;
        int               y;
        logic [KEY_W-1:0] tmp;
        if (full)
            set_operation(OP_UNION);
        else if ($urandom_range(0, 2) == 0)
            set_operation(op_t'($urandom_range(0, 3)));
        no_idle = ($urandom_range(0, 3) == 0);
        if (full || $urandom_range(0, 9) < 6)
            send_filler(KIND_CLEAR);
        if (full)
            build_full_sets();
        else
            build_small_sets();
        // now and then an unsorted A
        if (a_keys.size() >= 2 && $urandom_range(0, 7) == 0)
        begin
            x = $urandom_range(0, a_keys.size() - 1);
            y = $urandom_range(0, a_keys.size() - 1);
            tmp       = a_keys[x];
            a_keys[x] = a_keys[y];
            a_keys[y] = tmp;
        end
        // interleave the two loads
        ia = 0;
        ib = 0;
        while (ia < a_keys.size() || ib < b_keys.size())
        begin
            if (ib >= b_keys.size() || (ia < a_keys.size() && $urandom_range(0, 1) == 1))
            begin
                send_load(KIND_LOAD_A, a_keys[ia]);
                ia++;
            end
            else
            begin
                send_load(KIND_LOAD_B, b_keys[ib]);
                ib++;
            end
        end
        if ($urandom_range(0, 5) == 0)
            send_filler(kind_t'($urandom_range(0, 3)));
        send_filler(KIND_RUN);
        if ($urandom_range(0, 4) == 0)
            send_filler(KIND_RUN);
    endtask

    initial
    begin : stimulus
        int directed_end;
        int seq;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= KIND_LOAD_A;
        cfg_we     <= 1'b0;
        cfg_wdata  <= OP_UNION;
        no_idle    = 1'b0;
        items_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // union of two empty lists
        send_item(KIND_RUN, 16'h0000, 1'b0, 1'b0);
        // field extremes, union
        send_item(KIND_LOAD_A, 16'h0000, 1'b0, 1'b0);
        send_item(KIND_LOAD_A, 16'h5a5a, 1'b1, 1'b0);
        send_item(KIND_LOAD_A, 16'hffff, 1'b1, 1'b1);
        send_item(KIND_LOAD_B, 16'h0000, 1'b0, 1'b0);
        send_item(KIND_LOAD_B, 16'h1234, 1'b0, 1'b1);
        send_item(KIND_LOAD_B, 16'hffff, 1'b1, 1'b1);
        send_item(KIND_RUN, 16'hffff, 1'b1, 1'b1);
        // A contains B
        set_operation(OP_COMPARE);
        send_item(KIND_RUN, 16'h0000, 1'b0, 1'b0);
        // difference leaves one element
        set_operation(OP_DIFF);
        send_item(KIND_RUN, 16'h0000, 1'b0, 1'b0);
        // conflicting neighbors in A
        set_operation(OP_SANITY);
        send_item(KIND_LOAD_A, 16'h5a5a, 1'b1, 1'b1);
        send_item(KIND_RUN, 16'h0000, 1'b0, 1'b0);
        // compare: conflict, equal, B contains A, unrelated
        set_operation(OP_COMPARE);
        send_item(KIND_CLEAR, 16'h0000, 1'b0, 1'b0);
        send_item(KIND_LOAD_A, 16'd7, 1'b0, 1'b1);
        send_item(KIND_LOAD_B, 16'd7, 1'b0, 1'b0);
        send_item(KIND_RUN, 16'h0000, 1'b0, 1'b0);
        send_item(KIND_CLEAR, 16'h0000, 1'b0, 1'b0);
        send_item(KIND_LOAD_A, 16'd3, 1'b0, 1'b0);
        send_item(KIND_LOAD_B, 16'd3, 1'b0, 1'b0);
        send_item(KIND_RUN, 16'h0000, 1'b0, 1'b0);
        send_item(KIND_LOAD_B, 16'd9, 1'b1, 1'b0);
        send_item(KIND_RUN, 16'h0000, 1'b0, 1'b0);
        send_item(KIND_LOAD_A, 16'd20, 1'b0, 1'b0);
        send_item(KIND_RUN, 16'h0000, 1'b0, 1'b0);
        // difference with an empty result
        set_operation(OP_DIFF);
        send_item(KIND_CLEAR, 16'h0000, 1'b0, 1'b0);
        send_item(KIND_LOAD_A, 16'd5, 1'b0, 1'b0);
        send_item(KIND_LOAD_B, 16'd5, 1'b0, 1'b0);
        send_item(KIND_RUN, 16'h0000, 1'b0, 1'b0);

        // random sequences, the second one fills both lists
        directed_end = items_sent;
        seq = 0;
        while (items_sent < directed_end + RANDOM_ITEMS)
        begin
            random_sequence(seq == 1);
            seq++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
